// File: sv/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package spq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 5;
   localparam int ERROR_WIDTH = 2;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   localparam logic [ERROR_WIDTH-1:0] ERR_OK    = 2'd0;
   localparam logic [ERROR_WIDTH-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERROR_WIDTH-1:0] ERR_EMPTY = 2'd2;

   typedef struct packed {
      logic execute;
   } cmd_type;

endpackage

// File: sv/spq_controller.sv
// Handshake controller of the sorted priority queue.
// Depends on spq_pkg for the command struct.
module spq_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_HOLD = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) || rsp_ready;
      rsp_valid   = (state_ff == ST_HOLD);
      cmd.execute = req_valid && req_ready;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.execute) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (cmd.execute) begin
               state_in = ST_HOLD;
            end else if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/spq_datapath.sv
// Row of compare-and-shift cells, occupancy counter and result registers.
// Depends on spq_pkg for widths, codes and the command struct.
module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  spq_pkg::cmd_type                       cmd,
   input  logic                                   req_mode,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_top_value,
   output logic                                   rsp_top_valid,
   output logic        [spq_pkg::COUNT_WIDTH-1:0] rsp_count,
   output logic        [spq_pkg::ERROR_WIDTH-1:0] rsp_error
);

   localparam int OW = $clog2(DEPTH + 1);

   logic signed [spq_pkg::VALUE_WIDTH-1:0] slot_ff [DEPTH];
   logic signed [spq_pkg::VALUE_WIDTH-1:0] slot_in [DEPTH];
   logic [OW-1:0]                          occ_ff;
   logic [OW-1:0]                          occ_in;
   logic [DEPTH-1:0]                       ins_here;
   logic                                   full;
   logic                                   empty;
   logic [spq_pkg::ERROR_WIDTH-1:0]        err_in;
   logic [OW+spq_pkg::COUNT_WIDTH-1:0]     count_ext;

   logic signed [spq_pkg::VALUE_WIDTH-1:0] top_value_ff;
   logic                                   top_valid_ff;
   logic [spq_pkg::COUNT_WIDTH-1:0]        count_ff;
   logic [spq_pkg::ERROR_WIDTH-1:0]        error_ff;

   // A cell takes part in the insertion when it is empty or holds a smaller value.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ins_here[i] = (OW'(i) >= occ_ff) || (slot_ff[i] < req_push_value);
      end
   end

   always_comb begin
      full   = (occ_ff == OW'(DEPTH));
      empty  = (occ_ff == '0);
      occ_in = occ_ff;
      err_in = spq_pkg::ERR_OK;
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (req_mode == spq_pkg::MODE_PUSH) begin
         if (full) begin
            err_in = spq_pkg::ERR_FULL;
         end else begin
            occ_in = occ_ff + OW'(1);
            if (ins_here[0]) begin
               slot_in[0] = req_push_value;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (ins_here[i]) begin
                  slot_in[i] = ins_here[i-1] ? slot_ff[i-1] : req_push_value;
               end
            end
         end
      end else begin
         if (empty) begin
            err_in = spq_pkg::ERR_EMPTY;
         end else begin
            occ_in = occ_ff - OW'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot_in[i] = slot_ff[i+1];
            end
         end
      end
      count_ext = {{spq_pkg::COUNT_WIDTH{1'b0}}, occ_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < DEPTH; i++) begin
            slot_ff[i] <= slot_in[i];
         end
         top_value_ff <= (occ_in != '0) ? slot_in[0] : '0;
         top_valid_ff <= (occ_in != '0);
         count_ff     <= count_ext[spq_pkg::COUNT_WIDTH-1:0];
         error_ff     <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.execute) begin
         occ_ff <= occ_in;
      end
   end

   assign rsp_top_value = top_value_ff;
   assign rsp_top_valid = top_valid_ff;
   assign rsp_count     = count_ff;
   assign rsp_error     = error_ff;

endmodule

// File: sv/sorted_priority_queue.sv
// Sorted max-first priority queue of signed 32-bit values, DEPTH entries deep.
// Each transaction pushes a value or pops the top; one result follows each one.
// Top level: joins spq_controller and spq_datapath; depends on spq_pkg.
// A transaction is executed in the cycle it is accepted, in one step of a row
// of compare-and-shift cells, and its result is held in an output register the
// next cycle. A new transaction is accepted whenever that register is empty or
// being taken, so the queue sustains one transaction per cycle. Equal values
// leave in arrival order; pushes into a full queue and pops on an empty queue
// leave the contents unchanged and report an error code. No clearing pass.
module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_top_value,
   output logic                                   rsp_top_valid,
   output logic        [spq_pkg::COUNT_WIDTH-1:0] rsp_count,
   output logic        [spq_pkg::ERROR_WIDTH-1:0] rsp_error
);

   spq_pkg::cmd_type cmd;

   spq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_top_value  (rsp_top_value),
      .rsp_top_valid  (rsp_top_valid),
      .rsp_count      (rsp_count),
      .rsp_error      (rsp_error)
   );

endmodule

// File: tb/sv/spq_checker.sv
// Checker for the sorted priority queue: watches both channels, keeps its own
// sorted copy of the queue contents and compares every result with it.
// Depends on spq_pkg; instantiated beside the block by tb_top.
module spq_checker #(
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] req_push_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_top_value,
   input  logic                                   rsp_top_valid,
   input  logic        [spq_pkg::COUNT_WIDTH-1:0] rsp_count,
   input  logic        [spq_pkg::ERROR_WIDTH-1:0] rsp_error,
   output int                                     error_count,
   output int                                     checked_count,
   output int                                     pending_count
);

   typedef struct {
      logic signed [spq_pkg::VALUE_WIDTH-1:0] top_value;
      logic                                   top_valid;
      logic        [spq_pkg::COUNT_WIDTH-1:0] count;
      logic        [spq_pkg::ERROR_WIDTH-1:0] error;
   } queue_result_type;

   logic signed [spq_pkg::VALUE_WIDTH-1:0] sorted_values [DEPTH];
   int                                     stored;
   queue_result_type                       expected_results [$];
   int                                     mismatches = 0;
   int                                     compared = 0;

   assign error_count   = mismatches;
   assign checked_count = compared;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   task automatic apply_operation(input logic mode,
                                  input logic signed [spq_pkg::VALUE_WIDTH-1:0] value,
                                  output queue_result_type res);
      int pos;
      res.error = spq_pkg::ERR_OK;
      if (mode == spq_pkg::MODE_PUSH) begin
         if (stored >= DEPTH) begin
            res.error = spq_pkg::ERR_FULL;
         end else begin
            pos = stored;
            for (int i = 0; i < stored; i++) begin
               if (sorted_values[i] < value) begin
                  pos = i;
                  break;
               end
            end
            for (int i = stored; i > pos; i--) sorted_values[i] = sorted_values[i-1];
            sorted_values[pos] = value;
            stored++;
         end
      end else begin
         if (stored == 0) begin
            res.error = spq_pkg::ERR_EMPTY;
         end else begin
            for (int i = 0; i + 1 < stored; i++) sorted_values[i] = sorted_values[i+1];
            stored--;
         end
      end
      res.top_value = (stored != 0) ? sorted_values[0] : '0;
      res.top_valid = (stored != 0);
      res.count     = stored[spq_pkg::COUNT_WIDTH-1:0];
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      queue_result_type got;
      if (reset) begin
         stored = 0;
         expected_results.delete();
      end else begin
         // Results leave only after their transaction has been accepted, so check first.
         if (rsp_valid && rsp_ready) begin
            got.top_value = rsp_top_value;
            got.top_valid = rsp_top_valid;
            got.count     = rsp_count;
            got.error     = rsp_error;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected (top %0d count %0d)",
                                         got.top_value, got.count));
            end else begin
               want = expected_results.pop_front();
               compared++;
               if (got.top_value !== want.top_value)
                  report_mismatch($sformatf("result %0d top_value got %0d want %0d",
                                            compared, got.top_value, want.top_value));
               if (got.top_valid !== want.top_valid)
                  report_mismatch($sformatf("result %0d top_valid got %b want %b",
                                            compared, got.top_valid, want.top_valid));
               if (got.count !== want.count)
                  report_mismatch($sformatf("result %0d count got %0d want %0d",
                                            compared, got.count, want.count));
               if (got.error !== want.error)
                  report_mismatch($sformatf("result %0d error got %0d want %0d",
                                            compared, got.error, want.error));
            end
         end
         if (req_valid && req_ready) begin
            apply_operation(req_mode, req_push_value, want);
            expected_results.push_back(want);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
// Instantiates sorted_priority_queue and spq_checker; depends on spq_pkg.
module tb_top;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 1080;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic                                   req_mode = spq_pkg::MODE_PUSH;
   logic signed [spq_pkg::VALUE_WIDTH-1:0] req_push_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [spq_pkg::VALUE_WIDTH-1:0] rsp_top_value;
   logic                                   rsp_top_valid;
   logic        [spq_pkg::COUNT_WIDTH-1:0] rsp_count;
   logic        [spq_pkg::ERROR_WIDTH-1:0] rsp_error;

   int error_count;
   int checked_count;
   int pending_count;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int sent = 0;

   sorted_priority_queue #(.DEPTH(DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_top_value  (rsp_top_value),
      .rsp_top_valid  (rsp_top_valid),
      .rsp_count      (rsp_count),
      .rsp_error      (rsp_error)
   );

   spq_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_top_value  (rsp_top_value),
      .rsp_top_valid  (rsp_top_valid),
      .rsp_count      (rsp_count),
      .rsp_error      (rsp_error),
      .error_count    (error_count),
      .checked_count  (checked_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

   // The receiver counts down a long hold-off on its own, otherwise stalls at random.
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_op(input logic mode,
                          input logic signed [spq_pkg::VALUE_WIDTH-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   function automatic logic signed [spq_pkg::VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         4, 5:    return $signed($urandom_range(16)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   // Bursts lean toward pushes or pops, or are balanced, so the queue swings between full and empty.
   task automatic run_random(input int idle_pct, input int stall_pct, input int items);
      int burst_len;
      int push_pct;
      req_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      for (int done = 0; done < items; ) begin
         burst_len = $urandom_range(40, 8);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         for (int k = 0; k < burst_len && done < items; k++) begin
            if ($urandom_range(99) < push_pct) send_op(spq_pkg::MODE_PUSH, pick_value());
            else                               send_op(spq_pkg::MODE_POP, '0);
            done++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(spq_pkg::MODE_POP, '0);
      send_op(spq_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      send_op(spq_pkg::MODE_PUSH, 32'sh8000_0000);
      send_op(spq_pkg::MODE_PUSH, '0);
      send_op(spq_pkg::MODE_PUSH, -32'sd1);
      send_op(spq_pkg::MODE_PUSH, 32'sd1);
      send_op(spq_pkg::MODE_PUSH, 32'sd5);
      send_op(spq_pkg::MODE_PUSH, 32'sd5);
      send_op(spq_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      send_op(spq_pkg::MODE_PUSH, 32'sh8000_0000);
      send_op(spq_pkg::MODE_PUSH, 32'shAAAA_AAAA);
      send_op(spq_pkg::MODE_PUSH, 32'sh5555_5555);
      for (int i = 0; i < 5; i++) send_op(spq_pkg::MODE_PUSH, $signed($urandom));
      send_op(spq_pkg::MODE_PUSH, 32'sh7FFF_FFFF);
      for (int i = 0; i < 4; i++) send_op(spq_pkg::MODE_POP, '0);

      run_random(0, 0, RANDOM_ITEMS / 4);
      run_random(74, 0, RANDOM_ITEMS / 4);

      // Hold the receiver off while the sender keeps offering, so the queue backs up.
      req_idle_pct = 0;
      rsp_hold_left <= 300;
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(99) < 80) send_op(spq_pkg::MODE_PUSH, pick_value());
         else                         send_op(spq_pkg::MODE_POP, '0);
      end

      run_random(0, 74, RANDOM_ITEMS / 4);
      run_random(10, 10, RANDOM_ITEMS / 4);

      req_valid <= 1'b0;
      rsp_stall_pct <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d transactions: directed extremes, fill to full, pop on empty,", sent);
      $display("four idle/stall mixes and a long receiver hold-off; %0d results compared.",
               checked_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: files.f
sv/spq_pkg.sv
sv/spq_controller.sv
sv/spq_datapath.sv
sv/sorted_priority_queue.sv
tb/sv/spq_checker.sv
tb/sv/tb_top.sv
